/* design/differential_drive_odometry_unit_macros.svh */
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Concurrent assertion shorthands on clk with rst_n as the disable condition.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define DDO_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odometry assertion failed");

`define DDO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odometry assertion failed");

`else

`define DDO_ASSERT_SAME(lbl, ante, cons)

`define DDO_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* design/ddo_pkg.sv */
// ----------------------------------------------------------------------------
// Odometry package
// Shared constants, register map and CORDIC angle table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddo_pkg;

  localparam int CORDIC_STEPS     = 16;
  localparam int ANGLE_TABLE_SIZE = 24;
  localparam int ITER_W           = $clog2(ANGLE_TABLE_SIZE);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

  localparam int GAIN_W     = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_LSB = 2;
  localparam logic [0:0] REG_ANGLE_GAIN = 1'b0;
  localparam logic [GAIN_W-1:0] ANGLE_GAIN_RESET = 24'd8901;

  localparam logic signed [30:0] GAIN_INV_Q30 = 31'sd652032874;
  localparam logic signed [63:0] ROUND_BIAS   = 64'sd274877906944;

  function automatic logic signed [32:0] atan_turns(input logic [ITER_W-1:0] idx);
    logic signed [32:0] v;
    case (idx)
      5'd0:    v = 33'sd536870912;
      5'd1:    v = 33'sd316933406;
      5'd2:    v = 33'sd167458907;
      5'd3:    v = 33'sd85004756;
      5'd4:    v = 33'sd42667331;
      5'd5:    v = 33'sd21354465;
      5'd6:    v = 33'sd10679838;
      5'd7:    v = 33'sd5340245;
      5'd8:    v = 33'sd2670163;
      5'd9:    v = 33'sd1335087;
      5'd10:   v = 33'sd667544;
      5'd11:   v = 33'sd333772;
      5'd12:   v = 33'sd166886;
      5'd13:   v = 33'sd83443;
      5'd14:   v = 33'sd41722;
      5'd15:   v = 33'sd20861;
      5'd16:   v = 33'sd10430;
      5'd17:   v = 33'sd5215;
      5'd18:   v = 33'sd2608;
      5'd19:   v = 33'sd1304;
      5'd20:   v = 33'sd652;
      5'd21:   v = 33'sd326;
      5'd22:   v = 33'sd163;
      5'd23:   v = 33'sd81;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

endpackage

/* design/ddo_if.sv */
// ----------------------------------------------------------------------------
// Odometry channels
// Valid/ready channels for wheel samples and pose results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic        [15:0] elapsed;

  modport source (output valid, output left_speed, output right_speed, output elapsed,
                  input ready);
  modport sink   (input valid, input left_speed, input right_speed, input elapsed,
                  output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;

  modport source (output valid, output pos_x, output pos_y, output heading, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

/* design/ddo_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Odometry configuration registers
// APB register file holding the reciprocal wheel-base gain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ddo_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [ddo_pkg::GAIN_W-1:0]    angle_gain
);
  import ddo_pkg::*;

  logic [GAIN_W-1:0] gain_r;
  logic [GAIN_W-1:0] gain_nxt;
  logic              wr_en;
  logic [0:0]        reg_idx;

  assign reg_idx = paddr[CFG_IDX_LSB];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    gain_nxt = gain_r;
    if (wr_en && reg_idx == REG_ANGLE_GAIN) begin
      gain_nxt = pwdata[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= ANGLE_GAIN_RESET;
    end else begin
      gain_r <= gain_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ANGLE_GAIN: prdata = {{(32-GAIN_W){1'b0}}, gain_r};
      default:        prdata = '0;
    endcase
  end

  assign angle_gain = gain_r;

endmodule

/* design/differential_drive_odometry_unit.sv */
// ----------------------------------------------------------------------------
// Differential-drive odometry unit
// A wheel sample is taken only in S_IDLE; then S_SUM, S_DIFF, S_GAIN,
// S_ANGLE, S_ROT, S_MULX, S_MULY and S_POST run around one shared multiplier
// and one CORDIC add/shift stage; S_POST waits while an earlier result is unread.
// Reset: synchronous, active low; clears pose to zero and gain to 8901.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "differential_drive_odometry_unit_macros.svh"

module differential_drive_odometry_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  ddo_in_if.sink                         in_ch,
  ddo_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ddo_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ddo_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_DIFF, S_GAIN, S_ANGLE, S_ROT, S_MULX, S_MULY, S_POST
  } state_t;

  logic [GAIN_W-1:0] angle_gain;

  ddo_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .angle_gain (angle_gain)
  );

  state_t              state_r,   state_nxt;
  logic signed [15:0]  ls_r,      ls_nxt;
  logic signed [15:0]  rs_r,      rs_nxt;
  logic [15:0]         el_r,      el_nxt;
  logic signed [63:0]  prod_r,    prod_nxt;
  logic signed [31:0]  cx_r,      cx_nxt;
  logic signed [31:0]  cy_r,      cy_nxt;
  logic signed [32:0]  z_r,       z_nxt;
  logic [ITER_W-1:0]   iter_r,    iter_nxt;
  logic signed [31:0]  x_r,       x_nxt;
  logic signed [31:0]  y_r,       y_nxt;
  logic signed [15:0]  hdg_r,     hdg_nxt;
  logic signed [15:0]  hdg_new_r, hdg_new_nxt;
  logic                ovalid_r,  ovalid_nxt;
  logic signed [31:0]  opx_r,     opx_nxt;
  logic signed [31:0]  opy_r,     opy_nxt;
  logic signed [15:0]  ohdg_r,    ohdg_nxt;

  logic signed [32:0]  mul_a;
  logic signed [30:0]  mul_b;
  logic signed [63:0]  prod_w;
  logic signed [16:0]  sum17;
  logic signed [16:0]  diff17;
  logic signed [30:0]  el_op;
  logic signed [15:0]  mid_w;
  logic signed [15:0]  mid_f;
  logic                fold;
  logic signed [31:0]  sx;
  logic signed [31:0]  sy;
  logic signed [32:0]  atan_w;

  function automatic logic signed [31:0] acc_sat(input logic signed [31:0] base,
                                                  input logic signed [63:0] p);
    logic signed [63:0] r;
    logic signed [32:0] s;
    logic signed [31:0] q;
    r = (p + ROUND_BIAS) >>> 39;
    s = 33'(base) + 33'(signed'(r[24:0]));
    if (s[32] != s[31]) begin
      q = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      q = s[31:0];
    end
    return q;
  endfunction

  // shared multiplier
  assign sum17  = 17'(ls_r) + 17'(rs_r);
  assign diff17 = 17'(rs_r) - 17'(ls_r);
  assign el_op  = 31'(signed'({1'b0, el_r}));

  always_comb begin
    case (state_r)
      S_SUM: begin
        mul_a = 33'(sum17);
        mul_b = el_op;
      end
      S_DIFF: begin
        mul_a = 33'(diff17);
        mul_b = el_op;
      end
      S_GAIN: begin
        mul_a = prod_r[32:0];
        mul_b = 31'(signed'({1'b0, angle_gain}));
      end
      S_MULX: begin
        mul_a = 33'(cx_r);
        mul_b = GAIN_INV_Q30;
      end
      S_MULY: begin
        mul_a = 33'(cy_r);
        mul_b = GAIN_INV_Q30;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_w = 64'(mul_a) * 64'(mul_b);

  // midpoint heading and fold into the right half plane
  assign mid_w = hdg_r + signed'(prod_r[44:29]);
  assign fold  = (mid_w > 16'sd16384) || (mid_w < -16'sd16384);
  assign mid_f = fold ? {~mid_w[15], mid_w[14:0]} : mid_w;

  // CORDIC micro-rotation
  assign sx     = cx_r >>> iter_r;
  assign sy     = cy_r >>> iter_r;
  assign atan_w = atan_turns(iter_r);

  always_comb begin
    state_nxt   = state_r;
    ls_nxt      = ls_r;
    rs_nxt      = rs_r;
    el_nxt      = el_r;
    prod_nxt    = prod_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    z_nxt       = z_r;
    iter_nxt    = iter_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    hdg_nxt     = hdg_r;
    hdg_new_nxt = hdg_new_r;
    ovalid_nxt  = ovalid_r;
    opx_nxt     = opx_r;
    opy_nxt     = opy_r;
    ohdg_nxt    = ohdg_r;

    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          ls_nxt    = in_ch.left_speed;
          rs_nxt    = in_ch.right_speed;
          el_nxt    = in_ch.elapsed;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        prod_nxt  = prod_w;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cx_nxt    = 32'(prod_r >>> 4);
        prod_nxt  = prod_w;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        prod_nxt  = prod_w;
        state_nxt = S_ANGLE;
      end
      S_ANGLE: begin
        hdg_new_nxt = hdg_r + signed'(prod_r[43:28]);
        z_nxt       = {mid_f[15], mid_f, 16'd0};
        cx_nxt      = fold ? -cx_r : cx_r;
        cy_nxt      = '0;
        iter_nxt    = '0;
        state_nxt   = S_ROT;
      end
      S_ROT: begin
        if (!z_r[32]) begin
          cx_nxt = cx_r - sy;
          cy_nxt = cy_r + sx;
          z_nxt  = z_r - atan_w;
        end else begin
          cx_nxt = cx_r + sy;
          cy_nxt = cy_r - sx;
          z_nxt  = z_r + atan_w;
        end
        if (iter_r == ITER_LAST) begin
          state_nxt = S_MULX;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      S_MULX: begin
        prod_nxt  = prod_w;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        x_nxt     = acc_sat(x_r, prod_r);
        prod_nxt  = prod_w;
        state_nxt = S_POST;
      end
      S_POST: begin
        if (!ovalid_r || out_ch.ready) begin
          y_nxt      = acc_sat(y_r, prod_r);
          hdg_nxt    = hdg_new_r;
          opx_nxt    = x_r;
          opy_nxt    = acc_sat(y_r, prod_r);
          ohdg_nxt   = hdg_new_r;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      x_r      <= '0;
      y_r      <= '0;
      hdg_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      hdg_r    <= hdg_nxt;
    end
    ls_r      <= ls_nxt;
    rs_r      <= rs_nxt;
    el_r      <= el_nxt;
    prod_r    <= prod_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    z_r       <= z_nxt;
    iter_r    <= iter_nxt;
    hdg_new_r <= hdg_new_nxt;
    opx_r     <= opx_nxt;
    opy_r     <= opy_nxt;
    ohdg_r    <= ohdg_nxt;
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = ovalid_r;
  assign out_ch.pos_x   = opx_r;
  assign out_ch.pos_y   = opy_r;
  assign out_ch.heading = ohdg_r;

  `DDO_ASSERT_NEXT(a_transfer_starts, in_ch.valid && in_ch.ready, state_r == S_SUM)
  `DDO_ASSERT_NEXT(a_rot_exit, state_r == S_ROT && iter_r == ITER_LAST, state_r == S_MULX)
  `DDO_ASSERT_NEXT(a_fold_range, state_r == S_ANGLE, z_r <= 33'sd1073741824 && z_r >= -33'sd1073741824)
  `DDO_ASSERT_SAME(a_result_from_post, $rose(ovalid_r), $past(state_r) == S_POST)

endmodule
